// File: design/solar_to_lunar_date_macros.svh
// Assertion macros for the date converter checker
`ifndef SOLAR_TO_LUNAR_DATE_MACROS_SVH
`define SOLAR_TO_LUNAR_DATE_MACROS_SVH
`define STLD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define STLD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: design/stld_pkg.sv
package stld_pkg;
    localparam int TABLE_YEARS = 201;
    localparam int BASE_YEAR   = 1900;
    localparam int IDX_W       = 8;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DAYS, ST_YREAD, ST_YEAR, ST_MONTH, ST_DONE
    } state_t;

    typedef logic [16:0] year_word_t;

    function automatic year_word_t rom_word(input logic [IDX_W-1:0] idx);
        year_word_t r;
        unique case (idx)
            8'd0: r=17'h04bd8; 8'd1: r=17'h04ae0; 8'd2: r=17'h0a570; 8'd3: r=17'h054d5;
            8'd4: r=17'h0d260; 8'd5: r=17'h0d950; 8'd6: r=17'h16554; 8'd7: r=17'h056a0;
            8'd8: r=17'h09ad0; 8'd9: r=17'h055d2; 8'd10: r=17'h04ae0; 8'd11: r=17'h0a5b6;
            8'd12: r=17'h0a4d0; 8'd13: r=17'h0d250; 8'd14: r=17'h1d255; 8'd15: r=17'h0b540;
            8'd16: r=17'h0d6a0; 8'd17: r=17'h0ada2; 8'd18: r=17'h095b0; 8'd19: r=17'h14977;
            8'd20: r=17'h04970; 8'd21: r=17'h0a4b0; 8'd22: r=17'h0b4b5; 8'd23: r=17'h06a50;
            8'd24: r=17'h06d40; 8'd25: r=17'h1ab54; 8'd26: r=17'h02b60; 8'd27: r=17'h09570;
            8'd28: r=17'h052f2; 8'd29: r=17'h04970; 8'd30: r=17'h06566; 8'd31: r=17'h0d4a0;
            8'd32: r=17'h0ea50; 8'd33: r=17'h06e95; 8'd34: r=17'h05ad0; 8'd35: r=17'h02b60;
            8'd36: r=17'h186e3; 8'd37: r=17'h092e0; 8'd38: r=17'h1c8d7; 8'd39: r=17'h0c950;
            8'd40: r=17'h0d4a0; 8'd41: r=17'h1d8a6; 8'd42: r=17'h0b550; 8'd43: r=17'h056a0;
            8'd44: r=17'h1a5b4; 8'd45: r=17'h025d0; 8'd46: r=17'h092d0; 8'd47: r=17'h0d2b2;
            8'd48: r=17'h0a950; 8'd49: r=17'h0b557; 8'd50: r=17'h06ca0; 8'd51: r=17'h0b550;
            8'd52: r=17'h15355; 8'd53: r=17'h04da0; 8'd54: r=17'h0a5d0; 8'd55: r=17'h14573;
            8'd56: r=17'h052d0; 8'd57: r=17'h0a9a8; 8'd58: r=17'h0e950; 8'd59: r=17'h06aa0;
            8'd60: r=17'h0aea6; 8'd61: r=17'h0ab50; 8'd62: r=17'h04b60; 8'd63: r=17'h0aae4;
            8'd64: r=17'h0a570; 8'd65: r=17'h05260; 8'd66: r=17'h0f263; 8'd67: r=17'h0d950;
            8'd68: r=17'h05b57; 8'd69: r=17'h056a0; 8'd70: r=17'h096d0; 8'd71: r=17'h04dd5;
            8'd72: r=17'h04ad0; 8'd73: r=17'h0a4d0; 8'd74: r=17'h0d4d4; 8'd75: r=17'h0d250;
            8'd76: r=17'h0d558; 8'd77: r=17'h0b540; 8'd78: r=17'h0b5a0; 8'd79: r=17'h195a6;
            8'd80: r=17'h095b0; 8'd81: r=17'h049b0; 8'd82: r=17'h0a974; 8'd83: r=17'h0a4b0;
            8'd84: r=17'h0b27a; 8'd85: r=17'h06a50; 8'd86: r=17'h06d40; 8'd87: r=17'h0af46;
            8'd88: r=17'h0ab60; 8'd89: r=17'h09570; 8'd90: r=17'h04af5; 8'd91: r=17'h04970;
            8'd92: r=17'h064b0; 8'd93: r=17'h074a3; 8'd94: r=17'h0ea50; 8'd95: r=17'h06b58;
            8'd96: r=17'h055c0; 8'd97: r=17'h0ab60; 8'd98: r=17'h096d5; 8'd99: r=17'h092e0;
            8'd100: r=17'h0c960; 8'd101: r=17'h0d954; 8'd102: r=17'h0d4a0; 8'd103: r=17'h0da50;
            8'd104: r=17'h07552; 8'd105: r=17'h056a0; 8'd106: r=17'h0abb7; 8'd107: r=17'h025d0;
            8'd108: r=17'h092d0; 8'd109: r=17'h0cab5; 8'd110: r=17'h0a950; 8'd111: r=17'h0b4a0;
            8'd112: r=17'h0baa4; 8'd113: r=17'h0ad50; 8'd114: r=17'h055d9; 8'd115: r=17'h04ba0;
            8'd116: r=17'h0a5b0; 8'd117: r=17'h15176; 8'd118: r=17'h052b0; 8'd119: r=17'h0a930;
            8'd120: r=17'h07954; 8'd121: r=17'h06aa0; 8'd122: r=17'h0ad50; 8'd123: r=17'h05b52;
            8'd124: r=17'h04b60; 8'd125: r=17'h0a6e6; 8'd126: r=17'h0a4e0; 8'd127: r=17'h0d260;
            8'd128: r=17'h0ea65; 8'd129: r=17'h0d530; 8'd130: r=17'h05aa0; 8'd131: r=17'h076a3;
            8'd132: r=17'h096d0; 8'd133: r=17'h04afb; 8'd134: r=17'h04ad0; 8'd135: r=17'h0a4d0;
            8'd136: r=17'h1d0b6; 8'd137: r=17'h0d250; 8'd138: r=17'h0d520; 8'd139: r=17'h0dd45;
            8'd140: r=17'h0b5a0; 8'd141: r=17'h056d0; 8'd142: r=17'h055b2; 8'd143: r=17'h049b0;
            8'd144: r=17'h0a577; 8'd145: r=17'h0a4b0; 8'd146: r=17'h0aa50; 8'd147: r=17'h1b255;
            8'd148: r=17'h06d20; 8'd149: r=17'h0ada0; 8'd150: r=17'h14b63; 8'd151: r=17'h09370;
            8'd152: r=17'h049f8; 8'd153: r=17'h04970; 8'd154: r=17'h064b0; 8'd155: r=17'h168a6;
            8'd156: r=17'h0ea50; 8'd157: r=17'h06b20; 8'd158: r=17'h1a6c4; 8'd159: r=17'h0aae0;
            8'd160: r=17'h0a2e0; 8'd161: r=17'h0d2e3; 8'd162: r=17'h0c960; 8'd163: r=17'h0d557;
            8'd164: r=17'h0d4a0; 8'd165: r=17'h0da50; 8'd166: r=17'h05d55; 8'd167: r=17'h056a0;
            8'd168: r=17'h0a6d0; 8'd169: r=17'h055d4; 8'd170: r=17'h052d0; 8'd171: r=17'h0a9b8;
            8'd172: r=17'h0a950; 8'd173: r=17'h0b4a0; 8'd174: r=17'h0b6a6; 8'd175: r=17'h0ad50;
            8'd176: r=17'h055a0; 8'd177: r=17'h0aba4; 8'd178: r=17'h0a5b0; 8'd179: r=17'h052b0;
            8'd180: r=17'h0b273; 8'd181: r=17'h06930; 8'd182: r=17'h07337; 8'd183: r=17'h06aa0;
            8'd184: r=17'h0ad50; 8'd185: r=17'h14b55; 8'd186: r=17'h04b60; 8'd187: r=17'h0a570;
            8'd188: r=17'h054e4; 8'd189: r=17'h0d160; 8'd190: r=17'h0e968; 8'd191: r=17'h0d520;
            8'd192: r=17'h0daa0; 8'd193: r=17'h16aa6; 8'd194: r=17'h056d0; 8'd195: r=17'h04ae0;
            8'd196: r=17'h0a9d4; 8'd197: r=17'h0a2d0; 8'd198: r=17'h0d150; 8'd199: r=17'h0f252;
            8'd200: r=17'h0d520;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage

// File: design/stld_year_rom.sv
module stld_year_rom
    import stld_pkg::*;
(
    input  logic             aclk,
    input  logic [IDX_W-1:0] rd_addr,
    output year_word_t       rd_data
);
    // addresses past the last year read as zero
    always_ff @(posedge aclk) begin
        rd_data <= rom_word(rd_addr);
    end
endmodule

// File: design/solar_to_lunar_date.sv
// Gregorian to Chinese lunar date converter for 1900..2100. One item in,
// one result out. An item takes a day-counting step, then for each lunar
// year walked one synchronous read of the year-word ROM and one compare
// and subtract (up to 201 years), then up to 14 month steps (twelve
// months, a leap month and the overflow check) and a last step that moves
// the result into the output register. A new item is taken as soon as the
// previous result sits in the output register; a result still waiting
// there holds the next item in its last step. Errors give status 1 on
// m_tuser and all other fields zero.
module solar_to_lunar_date
    import stld_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // solar_year[11:0], solar_month[15:12], solar_day[20:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // lunar_year[11:0], lmonth[15:12], lunar_day[20:16],
                                  // leap_flag[21]
    output logic        m_tuser   // status: 1 on invalid input or out of table range
);
    // result word: leap, day, month, year, status from the top down
    localparam logic [22:0] ERR_RES = 23'd1;

    state_t state_reg, state_next;
    logic [11:0] y_reg;
    logic [3:0]  mo_reg;
    logic [4:0]  d_reg;
    logic [17:0] off_reg, off_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [3:0]  lm_reg, lm_next;
    logic        inleap_reg, inleap_next;
    year_word_t  w_reg;
    year_word_t  rom_q;
    logic [22:0] res_reg, res_next;
    logic [22:0] out_reg, out_next;
    logic        ov_reg, ov_next;

    stld_year_rom u_rom (.aclk(aclk), .rd_addr(idx_reg), .rd_data(rom_q));

    // day count, off = days from 1900-01-31
    logic [11:0] yy;
    logic [11:0] yk;
    logic [8:0]  mstart;
    logic [8:0]  doy;
    logic [2:0]  cent;
    logic [17:0] dn;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic        bad_in;

    always_comb begin
        yy = (mo_reg <= 4'd2) ? y_reg - 12'd1 : y_reg;
        // years counted from 1600 (multiple of 400), with yy >= 1899
        yk = yy - 12'd1600;
        // days from March 1st to the first of the month
        unique case (mo_reg)
            4'd1:    mstart = 9'd306;
            4'd2:    mstart = 9'd337;
            4'd3:    mstart = 9'd0;
            4'd4:    mstart = 9'd31;
            4'd5:    mstart = 9'd61;
            4'd6:    mstart = 9'd92;
            4'd7:    mstart = 9'd122;
            4'd8:    mstart = 9'd153;
            4'd9:    mstart = 9'd184;
            4'd10:   mstart = 9'd214;
            4'd11:   mstart = 9'd245;
            4'd12:   mstart = 9'd275;
            default: mstart = 9'd0;
        endcase
        doy = mstart + 9'(d_reg) - 9'd1;
        cent = 3'(yk >= 12'd100) + 3'(yk >= 12'd200) + 3'(yk >= 12'd300)
             + 3'(yk >= 12'd400) + 3'(yk >= 12'd500);
        // a year 2000 and later also gets the 400-year leap day
        dn  = 18'(yk) * 18'd365 + 18'(yk >> 2) - 18'(cent)
            + 18'(yk >= 12'd400) + 18'(doy);
        ylen = 9'd348 + 9'($countones(rom_q[15:4]))
             + ((rom_q[3:0] == 4'd0) ? 9'd0 : (rom_q[16] ? 9'd30 : 9'd29));
        mlen = w_reg[5'd16 - 5'(lm_reg)] ? 5'd30 : 5'd29;
        bad_in = (y_reg < 12'(BASE_YEAR)) || (y_reg > 12'(BASE_YEAR + TABLE_YEARS - 1))
               || (mo_reg == 4'd0) || (mo_reg > 4'd12) || (d_reg == 5'd0);
    end

    // 1899-03-01 based: dn of 1900-01-31 from 1600 epoch
    localparam logic [17:0] BASE_DN = 18'(299 * 365 + 299 / 4 - 299 / 100 + 336);

    always_comb begin
        state_next  = state_reg;
        off_next    = off_reg;
        idx_next    = idx_reg;
        lm_next     = lm_reg;
        inleap_next = inleap_reg;
        res_next    = res_reg;
        out_next    = out_reg;
        ov_next     = ov_reg;
        if (ov_reg && m_tready) ov_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DAYS;
            end
            ST_DAYS: begin
                idx_next = '0;
                if (bad_in || dn < BASE_DN) begin
                    res_next = ERR_RES;
                    state_next = ST_DONE;
                end else begin
                    off_next = dn - BASE_DN;
                    state_next = ST_YREAD;
                end
            end
            ST_YREAD: begin
                if (idx_reg >= IDX_W'(TABLE_YEARS)) begin
                    res_next = ERR_RES;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR: begin
                if (off_reg < 18'(ylen)) begin
                    lm_next = 4'd1;
                    inleap_next = 1'b0;
                    state_next = ST_MONTH;
                end else begin
                    off_next = off_reg - 18'(ylen);
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_YREAD;
                end
            end
            ST_MONTH: begin
                if (lm_reg > 4'd12) begin
                    res_next = ERR_RES;
                    state_next = ST_DONE;
                end else if (inleap_reg) begin
                    if (off_reg < 18'(w_reg[16] ? 5'd30 : 5'd29)) begin
                        res_next = {1'b1, 5'(off_reg + 18'd1), lm_reg,
                                    12'(BASE_YEAR) + 12'(idx_reg), 1'b0};
                        state_next = ST_DONE;
                    end else begin
                        off_next = off_reg - 18'(w_reg[16] ? 5'd30 : 5'd29);
                        inleap_next = 1'b0;
                        lm_next = lm_reg + 4'd1;
                    end
                end else if (off_reg < 18'(mlen)) begin
                    res_next = {1'b0, 5'(off_reg + 18'd1), lm_reg,
                                12'(BASE_YEAR) + 12'(idx_reg), 1'b0};
                    state_next = ST_DONE;
                end else begin
                    off_next = off_reg - 18'(mlen);
                    if (lm_reg == w_reg[3:0]) inleap_next = 1'b1;
                    else lm_next = lm_reg + 4'd1;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!ov_reg || m_tready) begin
                    out_next = res_reg;
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            y_reg  <= s_tdata[11:0];
            mo_reg <= s_tdata[15:12];
            d_reg  <= s_tdata[20:16];
        end
        if (state_reg == ST_YEAR) w_reg <= rom_q;
        off_reg    <= off_next;
        idx_reg    <= idx_next;
        lm_reg     <= lm_next;
        inleap_reg <= inleap_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = {2'b00, out_reg[22:1]};
    assign m_tuser  = out_reg[0];
endmodule

// File: design/stld_checker.sv
`include "solar_to_lunar_date_macros.svh"
module stld_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);
    `STLD_ASSERT_IMP(a_err_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == 24'd0)
    `STLD_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `STLD_ASSERT_NXT(a_one_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `STLD_ASSERT_IMP(a_day_rng, aclk, aresetn, m_tvalid && !m_tuser,
        m_tdata[20:16] != 5'd0 && m_tdata[15:12] != 4'd0)
endmodule

bind solar_to_lunar_date stld_checker u_chk (.*);

// File: dv/tb_solar_to_lunar_date.sv
`timescale 1ns / 100ps

module tb_solar_to_lunar_date;
    import stld_pkg::*;

    typedef struct packed {
        logic        leap;
        logic [4:0]  lday;
        logic [3:0]  lmonth;
        logic [11:0] lyear;
        logic        status;
    } lunar_date_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    lunar_date_t expected_dates[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_off_cycles = 0;

    solar_to_lunar_date uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 5000000) begin
            $display("** solar_to_lunar_date: FAILED **");
            $finish;
        end
    end

    // ROM word table, kept apart from the package's function
    localparam logic [16:0] YEAR_WORDS [0:200] = '{
        17'h04bd8,17'h04ae0,17'h0a570,17'h054d5,17'h0d260,17'h0d950,17'h16554,17'h056a0,
        17'h09ad0,17'h055d2,17'h04ae0,17'h0a5b6,17'h0a4d0,17'h0d250,17'h1d255,17'h0b540,
        17'h0d6a0,17'h0ada2,17'h095b0,17'h14977,17'h04970,17'h0a4b0,17'h0b4b5,17'h06a50,
        17'h06d40,17'h1ab54,17'h02b60,17'h09570,17'h052f2,17'h04970,17'h06566,17'h0d4a0,
        17'h0ea50,17'h06e95,17'h05ad0,17'h02b60,17'h186e3,17'h092e0,17'h1c8d7,17'h0c950,
        17'h0d4a0,17'h1d8a6,17'h0b550,17'h056a0,17'h1a5b4,17'h025d0,17'h092d0,17'h0d2b2,
        17'h0a950,17'h0b557,17'h06ca0,17'h0b550,17'h15355,17'h04da0,17'h0a5d0,17'h14573,
        17'h052d0,17'h0a9a8,17'h0e950,17'h06aa0,17'h0aea6,17'h0ab50,17'h04b60,17'h0aae4,
        17'h0a570,17'h05260,17'h0f263,17'h0d950,17'h05b57,17'h056a0,17'h096d0,17'h04dd5,
        17'h04ad0,17'h0a4d0,17'h0d4d4,17'h0d250,17'h0d558,17'h0b540,17'h0b5a0,17'h195a6,
        17'h095b0,17'h049b0,17'h0a974,17'h0a4b0,17'h0b27a,17'h06a50,17'h06d40,17'h0af46,
        17'h0ab60,17'h09570,17'h04af5,17'h04970,17'h064b0,17'h074a3,17'h0ea50,17'h06b58,
        17'h055c0,17'h0ab60,17'h096d5,17'h092e0,17'h0c960,17'h0d954,17'h0d4a0,17'h0da50,
        17'h07552,17'h056a0,17'h0abb7,17'h025d0,17'h092d0,17'h0cab5,17'h0a950,17'h0b4a0,
        17'h0baa4,17'h0ad50,17'h055d9,17'h04ba0,17'h0a5b0,17'h15176,17'h052b0,17'h0a930,
        17'h07954,17'h06aa0,17'h0ad50,17'h05b52,17'h04b60,17'h0a6e6,17'h0a4e0,17'h0d260,
        17'h0ea65,17'h0d530,17'h05aa0,17'h076a3,17'h096d0,17'h04afb,17'h04ad0,17'h0a4d0,
        17'h1d0b6,17'h0d250,17'h0d520,17'h0dd45,17'h0b5a0,17'h056d0,17'h055b2,17'h049b0,
        17'h0a577,17'h0a4b0,17'h0aa50,17'h1b255,17'h06d20,17'h0ada0,17'h14b63,17'h09370,
        17'h049f8,17'h04970,17'h064b0,17'h168a6,17'h0ea50,17'h06b20,17'h1a6c4,17'h0aae0,
        17'h0a2e0,17'h0d2e3,17'h0c960,17'h0d557,17'h0d4a0,17'h0da50,17'h05d55,17'h056a0,
        17'h0a6d0,17'h055d4,17'h052d0,17'h0a9b8,17'h0a950,17'h0b4a0,17'h0b6a6,17'h0ad50,
        17'h055a0,17'h0aba4,17'h0a5b0,17'h052b0,17'h0b273,17'h06930,17'h07337,17'h06aa0,
        17'h0ad50,17'h14b55,17'h04b60,17'h0a570,17'h054e4,17'h0d160,17'h0e968,17'h0d520,
        17'h0daa0,17'h16aa6,17'h056d0,17'h04ae0,17'h0a9d4,17'h0a2d0,17'h0d150,17'h0f252,
        17'h0d520
    };

    function automatic int leap_month_days(logic [16:0] w);
        if (w[3:0] == 4'd0) return 0;
        return w[16] ? 30 : 29;
    endfunction

    function automatic int civil_day_number(int y, int m, int d);
        int yy, era, yoe, doy;
        yy = (m <= 2) ? y - 1 : y;
        era = yy / 400;
        yoe = yy - era * 400;
        doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
        return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy - 719468;
    endfunction

    function automatic lunar_date_t convert_date(int y, int m, int d);
        lunar_date_t r;
        int off, idx, len, lm, k;
        logic [16:0] w;
        r = '0;
        r.status = 1'b1;
        if (y < BASE_YEAR || y > BASE_YEAR - 1 + TABLE_YEARS || m < 1 || m > 12 || d < 1)
            return r;
        off = civil_day_number(y, m, d) - civil_day_number(BASE_YEAR, 1, 31);
        if (off < 0) return r;
        for (idx = 0; idx < TABLE_YEARS; idx++) begin
            w = YEAR_WORDS[idx];
            len = 348 + leap_month_days(w);
            for (k = 4; k <= 15; k++) len += w[k];
            if (off < len) break;
            off -= len;
        end
        if (idx >= TABLE_YEARS) return r;
        w = YEAR_WORDS[idx];
        for (lm = 1; lm <= 12; lm++) begin
            len = w[16 - lm] ? 30 : 29;
            if (off < len) break;
            off -= len;
            if (lm == w[3:0]) begin
                len = leap_month_days(w);
                if (off < len) begin
                    r.leap = 1'b1;
                    break;
                end
                off -= len;
            end
        end
        if (lm > 12) return r;
        r.status = 1'b0;
        r.lyear = 12'(BASE_YEAR + idx);
        r.lmonth = 4'(lm);
        r.lday = 5'(off + 1);
        return r;
    endfunction

    // tvalid stays high after an accept until the next idle cycle or drain
    task automatic send_date(int y, int m, int d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b0, 5'(d), 4'(m), 12'(y)};
        expected_dates.push_back(convert_date(y & 12'hfff, m & 4'hf, d & 5'h1f));
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_dates.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        lunar_date_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = lunar_date_t'({m_tdata[21:0], m_tuser});
            if (expected_dates.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                fail_count++;
            end else begin
                want = expected_dates.pop_front();
                if (got !== want || m_tdata[23:22] !== 2'b00) begin
                    $display("%0t: mismatch expected %h actual %h user %b",
                             $time, want, m_tdata, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_directed();
        send_date(1900, 1, 31);
        send_date(1900, 1, 30);
        send_date(1899, 12, 31);
        send_date(2100, 12, 31);
        send_date(2101, 1, 1);
        send_date(4095, 15, 31);
        send_date(0, 0, 0);
        send_date(2000, 0, 5);
        send_date(2000, 13, 5);
        send_date(2000, 6, 0);
        send_date(2001, 2, 31);
        send_date(2000, 2, 31);
        send_date(1900, 12, 31);
        send_date(2020, 5, 23);
        send_date(2020, 6, 21);
        send_date(2023, 3, 22);
        send_date(2023, 4, 20);
        send_date(2099, 12, 31);
        send_date(2100, 2, 10);
        send_date(1999, 12, 31);
        wait_drained();
    endtask

    task automatic test_random(int n);
        int kind;
        repeat (n) begin
            kind = $urandom_range(9);
            if (kind < 7)
                send_date($urandom_range(2100, 1900), $urandom_range(12, 1),
                          $urandom_range(31, 1));
            else if (kind < 8)
                send_date($urandom_range(2100, 2099), $urandom_range(12, 1),
                          $urandom_range(31, 1));
            else
                send_date($urandom_range(4095), $urandom_range(15), $urandom_range(31));
        end
    endtask

    task automatic test_backpressure();
        hold_off_cycles <= 3000;
        test_random(8);
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(400);
        send_idle_pct = 69;
        test_random(400);
        send_idle_pct = 0;
        recv_stall_pct = 69;
        test_random(400);
        send_idle_pct = 38;
        recv_stall_pct = 38;
        test_random(400);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();
        test_random(200);
        wait_drained();
        repeat (500) @(posedge aclk);
        if (fail_count == 0 && expected_dates.size() == 0)
            $display("** solar_to_lunar_date: PASSED **");
        else
            $display("** solar_to_lunar_date: FAILED **");
        $finish;
    end
endmodule
